FILE: rtl/tpat_pkg.sv
// Package for the triac phase-angle trigger unit.
// Holds field widths, item codes, register indexes, reset values and payload types.
// No dependencies; every other file of the block imports it.
package tpat_pkg;

  // Field widths of the transaction payloads and state.
  localparam int FIELD_W   = 12;
  localparam int ELAPSED_W = 13;
  localparam int REQ_W     = 16;
  localparam int MODE_W    = 2;

  // Default width of the delay down-counter.
  localparam int DEF_COUNT_WIDTH = 12;

  // Elapsed time saturates at the top of its range.
  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = {ELAPSED_W{1'b1}};

  // Item codes carried in the mode field.
  localparam logic [MODE_W-1:0] MODE_TICK     = 2'd0;
  localparam logic [MODE_W-1:0] MODE_EDGE     = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DURATION = 2'd2;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_DELAY  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT_GAP = 1'd1;

  // Register reset values.
  localparam logic [FIELD_W-1:0] MAX_DELAY_RST  = 12'd864;
  localparam logic [FIELD_W-1:0] REPEAT_GAP_RST = 12'd20;

  // One input item.
  typedef struct packed {
    logic [MODE_W-1:0]       mode;
    logic                    line_level;
    logic signed [REQ_W-1:0] duration_request;
  } item_t;

  // One result item.
  typedef struct packed {
    logic               fire;
    logic               running;
    logic [FIELD_W-1:0] fire_duration;
  } result_t;

  // Configuration values handed to the datapath.
  typedef struct packed {
    logic [FIELD_W-1:0] max_delay;
    logic [FIELD_W-1:0] repeat_gap;
  } cfg_t;

endpackage

FILE: rtl/tpat_if.sv
// Valid/ready channel interfaces for the triac phase-angle trigger unit.
// Depends on tpat_pkg for field widths.
interface tpat_in_if import tpat_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [MODE_W-1:0]       mode;
  logic                    line_level;
  logic signed [REQ_W-1:0] duration_request;

  modport source (output valid, output mode, output line_level,
                  output duration_request, input ready);
  modport sink (input valid, input mode, input line_level,
                input duration_request, output ready);
endinterface

interface tpat_out_if import tpat_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               fire;
  logic               running;
  logic [FIELD_W-1:0] fire_duration;

  modport source (output valid, output fire, output running,
                  output fire_duration, input ready);
  modport sink (input valid, input fire, input running,
                input fire_duration, output ready);
endinterface

FILE: rtl/tpat_core.sv
// Firing state and next-state logic of the triac phase-angle trigger unit.
// Processes one registered item per commit; depends on tpat_pkg.
module tpat_core import tpat_pkg::*; #(
  parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    commit,
  input  item_t   item,
  input  cfg_t    cfg,
  output result_t result
);

  localparam int COUNT_MAX_I = (1 << COUNT_WIDTH) - 1;

  logic                   running_r, running_nxt;
  logic [COUNT_WIDTH-1:0] remaining_r, remaining_nxt;
  logic [ELAPSED_W-1:0]   elapsed_r, elapsed_nxt;
  logic [FIELD_W-1:0]     held_r, held_nxt;

  logic signed [FIELD_W+1:0] start_delay;
  logic signed [FIELD_W+1:0] gap_delay;
  logic [FIELD_W-1:0]        start_arm;
  logic [FIELD_W-1:0]        gap_arm;
  logic [COUNT_WIDTH-1:0]    remaining_dec;
  logic [ELAPSED_W:0]        elapsed_gap_sum;
  logic signed [REQ_W:0]     req_ext;
  logic signed [REQ_W:0]     maxd_ext;
  logic                      fire;

  // Clamp an armed delay to at least one tick and at most the counter's range.
  function automatic logic [FIELD_W-1:0] clamp_delay(input logic signed [FIELD_W+1:0] d);
    logic [FIELD_W-1:0] res;
    if (d < 1) begin
      res = FIELD_W'(1);
    end else if (d > COUNT_MAX_I) begin
      res = FIELD_W'(COUNT_MAX_I);
    end else begin
      res = FIELD_W'(d);
    end
    return res;
  endfunction

  // Candidate delays for a half-cycle start and for a repeat pulse.
  assign start_delay = $signed({2'b00, cfg.max_delay}) - $signed({2'b00, held_r});
  assign gap_delay   = $signed({2'b00, cfg.repeat_gap});
  assign start_arm   = clamp_delay(start_delay);
  assign gap_arm     = clamp_delay(gap_delay);

  assign remaining_dec   = (remaining_r != '0) ? remaining_r - 1'b1 : remaining_r;
  assign elapsed_gap_sum = {1'b0, elapsed_r} + (ELAPSED_W + 1)'(gap_arm);
  assign req_ext         = {item.duration_request[REQ_W-1], item.duration_request};
  assign maxd_ext        = $signed({(REQ_W - FIELD_W + 1)'(0), cfg.max_delay});

  // Next state for the item in hand.
  always_comb begin
    running_nxt   = running_r;
    remaining_nxt = remaining_r;
    elapsed_nxt   = elapsed_r;
    held_nxt      = held_r;
    fire          = 1'b0;
    case (item.mode)
      MODE_TICK: begin
        if (running_r) begin
          remaining_nxt = remaining_dec;
          if (remaining_dec == '0) begin
            fire = 1'b1;
            if (elapsed_r >= {1'b0, cfg.max_delay}) begin
              running_nxt = 1'b0;
            end else begin
              remaining_nxt = COUNT_WIDTH'(gap_arm);
              elapsed_nxt   = (elapsed_gap_sum > {1'b0, ELAPSED_MAX}) ?
                              ELAPSED_MAX : elapsed_gap_sum[ELAPSED_W-1:0];
              running_nxt   = 1'b1;
            end
          end
        end
      end
      MODE_EDGE: begin
        if (item.line_level) begin
          running_nxt = 1'b0;
        end else begin
          // Elapsed restarts at zero, so it takes the armed delay directly.
          elapsed_nxt = '0;
          if (held_r != '0) begin
            remaining_nxt = COUNT_WIDTH'(start_arm);
            elapsed_nxt   = ELAPSED_W'(start_arm);
            running_nxt   = 1'b1;
          end
        end
      end
      MODE_DURATION: begin
        if (req_ext < maxd_ext) begin
          held_nxt = (req_ext > 0) ? item.duration_request[FIELD_W-1:0] : '0;
        end else begin
          held_nxt = cfg.max_delay;
        end
      end
      default: begin
      end
    endcase
  end

  // State registers, updated once per committed item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r   <= 1'b0;
      remaining_r <= '0;
      elapsed_r   <= '0;
      held_r      <= '0;
    end else if (commit) begin
      running_r   <= running_nxt;
      remaining_r <= remaining_nxt;
      elapsed_r   <= elapsed_nxt;
      held_r      <= held_nxt;
    end
  end

  assign result.fire          = fire;
  assign result.running       = running_nxt;
  assign result.fire_duration = held_nxt;

endmodule

FILE: rtl/triac_phase_angle_trigger_unit.sv
// Top level of the triac phase-angle trigger unit: channels, registers, pipeline.
// Depends on tpat_pkg, tpat_if and tpat_core.
//
// Phase-angle triac firing controller. Each input transaction is a timer tick,
// a zero-cross edge or a new fire duration, and each gives exactly one result
// transaction (fire strobe, running flag, held duration). An item is taken
// into an input register, processed against the firing state, and its result
// lands in an output register; a new item is accepted every cycle while the
// output side keeps up. The output register stalls the pipeline only when a
// result waits untaken. Configuration must be written by the user with
// cfg_we, cfg_index and cfg_wdata only while no item is in flight; the
// block itself does not enforce this.
module triac_phase_angle_trigger_unit import tpat_pkg::*; #(
  parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  tpat_in_if.sink              in_ch,
  tpat_out_if.source           out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [FIELD_W-1:0]   cfg_wdata
);

  logic [FIELD_W-1:0] max_delay_r;
  logic [FIELD_W-1:0] repeat_gap_r;
  logic               s1_valid_r;
  item_t              s1_item_r;
  logic               out_valid_r;
  result_t            out_res_r;
  logic               out_load;
  logic               commit;
  cfg_t               cfg;
  result_t            core_res;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_delay_r  <= MAX_DELAY_RST;
      repeat_gap_r <= REPEAT_GAP_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MAX_DELAY:  max_delay_r  <= cfg_wdata;
        REG_REPEAT_GAP: repeat_gap_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  assign cfg.max_delay  = max_delay_r;
  assign cfg.repeat_gap = repeat_gap_r;

  // Handshake: the output register loads when empty or being drained.
  assign out_load    = !out_valid_r || out_ch.ready;
  assign commit      = s1_valid_r && out_load;
  assign in_ch.ready = !s1_valid_r || out_load;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_item_r.mode             <= in_ch.mode;
      s1_item_r.line_level       <= in_ch.line_level;
      s1_item_r.duration_request <= in_ch.duration_request;
    end
  end

  tpat_core #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .commit (commit),
    .item   (s1_item_r),
    .cfg    (cfg),
    .result (core_res)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_res_r <= core_res;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.fire          = out_res_r.fire;
  assign out_ch.running       = out_res_r.running;
  assign out_ch.fire_duration = out_res_r.fire_duration;

endmodule

FILE: tb/tb_triac_phase_angle_trigger_unit.sv
// Self-checking testbench for the triac phase-angle trigger unit.
// A directed table and random firing sequences are scored against a cycle-free predictor.
// Depends on tpat_pkg, the channel interfaces in tpat_if and the unit's top level.
module tb_triac_phase_angle_trigger_unit;
  import tpat_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // Mode code that the unit leaves without effect.
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam int COUNT_MAX = (1 << DEF_COUNT_WIDTH) - 1;
  localparam int ELAPSED_TOP = (1 << ELAPSED_W) - 1;
  localparam int HOLD_CYCLES = 60;
  localparam int NUM_PHASES = 6;

  // One row of the directed stimulus table.
  typedef struct {
    bit                   is_cfg;
    logic [CFG_IDX_W-1:0] idx;
    logic [FIELD_W-1:0]   val;
    item_t                it;
    bit                   typed;
    result_t              exp;
  } dir_row_t;

  logic clk;
  logic rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [FIELD_W-1:0]   cfg_wdata;

  tpat_in_if  in_ch ();
  tpat_out_if out_ch ();

  triac_phase_angle_trigger_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Predicted firing state and register copies.
  bit armed;
  int ticks_left;
  int elapsed_ticks;
  int held_ticks;
  int window_ticks;
  int gap_ticks;

  result_t fire_status_q[$];
  dir_row_t dir_rows[$];

  int src_idle_pct;
  int snk_idle_pct;
  int holds_asked;
  int holds_done;
  int errors;
  int results_seen;
  int fires_seen;
  int random_sent;
  int settings_used;

  int phase_win [NUM_PHASES] = '{12, 1, 4095, 40, 0, 5};
  int phase_gap [NUM_PHASES] = '{3, 1, 4095, 7, 0, 4095};
  int phase_len [NUM_PHASES] = '{66, 66, 66, 66, 40, 66};

  // Loads a delay into the countdown and adds it to the elapsed time.
  function automatic void arm_countdown(int d);
    if (d < 1) d = 1;
    if (d > COUNT_MAX) d = COUNT_MAX;
    ticks_left = d;
    elapsed_ticks = elapsed_ticks + d;
    if (elapsed_ticks > ELAPSED_TOP) elapsed_ticks = ELAPSED_TOP;
    armed = 1'b1;
  endfunction

  // Applies one item to the predicted state and returns the status it reports.
  function automatic result_t next_fire_status(item_t it);
    result_t r;
    int req;
    req = it.duration_request;
    r.fire = 1'b0;
    case (it.mode)
      MODE_TICK: begin
        if (armed) begin
          if (ticks_left > 0) ticks_left = ticks_left - 1;
          if (ticks_left == 0) begin
            r.fire = 1'b1;
            if (elapsed_ticks >= window_ticks) armed = 1'b0;
            else arm_countdown(gap_ticks);
          end
        end
      end
      MODE_EDGE: begin
        if (it.line_level) begin
          armed = 1'b0;
        end else begin
          elapsed_ticks = 0;
          if (held_ticks > 0) arm_countdown(window_ticks - held_ticks);
        end
      end
      MODE_DURATION: begin
        if (req < window_ticks) held_ticks = (req > 0) ? req : 0;
        else held_ticks = window_ticks;
      end
      default: begin
      end
    endcase
    r.running = armed;
    r.fire_duration = held_ticks[FIELD_W-1:0];
    return r;
  endfunction

  function automatic item_t make_item(logic [MODE_W-1:0] m, logic l, int req);
    item_t it;
    it.mode = m;
    it.line_level = l;
    it.duration_request = REQ_W'(req);
    return it;
  endfunction

  function automatic dir_row_t item_row(logic [MODE_W-1:0] m, logic l, int req);
    dir_row_t row;
    row = '{default: '0};
    row.it = make_item(m, l, req);
    return row;
  endfunction

  function automatic dir_row_t checked_row(logic [MODE_W-1:0] m, logic l, int req,
                                           logic f, logic run, int dur);
    dir_row_t row;
    row = item_row(m, l, req);
    row.typed = 1'b1;
    row.exp.fire = f;
    row.exp.running = run;
    row.exp.fire_duration = FIELD_W'(dur);
    return row;
  endfunction

  function automatic dir_row_t cfg_row(logic [CFG_IDX_W-1:0] idx, int val);
    dir_row_t row;
    row = '{default: '0};
    row.is_cfg = 1'b1;
    row.idx = idx;
    row.val = FIELD_W'(val);
    return row;
  endfunction

  // Offers one transaction after random idle cycles; called and left at a falling edge.
  task automatic send_item(item_t it, bit typed, result_t exp);
    result_t predicted;
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.mode <= it.mode;
    in_ch.line_level <= it.line_level;
    in_ch.duration_request <= it.duration_request;
    do @(posedge clk); while (!in_ch.ready);
    predicted = next_fire_status(it);
    fire_status_q.push_back(typed ? exp : predicted);
    @(negedge clk);
  endtask

  // Stops offering and waits until every expected result has come back.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (fire_status_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Writes one register while the unit is idle.
  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [FIELD_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_MAX_DELAY) window_ticks = val;
    else gap_ticks = val;
    @(negedge clk);
  endtask

  // Random firing sequences with some noise for one register setting.
  task automatic run_phase(int phase, int count);
    int sent;
    int n;
    int req;
    int win;
    bit paused;
    result_t none;
    none = '0;
    sent = 0;
    paused = 1'b0;
    win = window_ticks;
    while (sent < count) begin
      if (phase == 0 && sent >= 20 && holds_asked == 0) holds_asked++;
      if (phase == 3 && sent >= 30 && !paused) begin
        drain();
        paused = 1'b1;
      end
      if ($urandom_range(99) < 80) begin
        // Well-formed half cycle: duration, low edge, ticks, maybe a high edge.
        case ($urandom_range(3))
          0: req = $signed(16'($urandom));
          1: req = win - int'($urandom_range(8));
          default: req = $urandom_range(win + 3);
        endcase
        send_item(make_item(MODE_DURATION, 1'($urandom_range(1)), req), 1'b0, none);
        send_item(make_item(MODE_EDGE, 1'b0, $urandom), 1'b0, none);
        n = $urandom_range(40, 1);
        repeat (n) begin
          send_item(make_item(MODE_TICK, 1'($urandom_range(1)), $urandom), 1'b0, none);
        end
        sent = sent + n + 2;
        if ($urandom_range(99) < 30) begin
          send_item(make_item(MODE_EDGE, 1'b1, $urandom), 1'b0, none);
          sent++;
        end
      end else begin
        send_item(make_item(MODE_W'($urandom_range(3)), 1'($urandom_range(1)), $urandom),
                  1'b0, none);
        sent++;
      end
    end
    random_sent = random_sent + sent;
  endtask

  // Clock.
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Result side: random stalls, plus one long hold-off on request.
  initial begin
    int hold_left;
    hold_left = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (holds_done != holds_asked) begin
        holds_done++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  // Scoreboard: each result transaction against the oldest expectation.
  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (out_ch.fire) fires_seen++;
      if (fire_status_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("Unexpected result transaction: fire=%0b running=%0b dur=%0d",
                   out_ch.fire, out_ch.running, out_ch.fire_duration);
      end else begin
        want = fire_status_q.pop_front();
        if (out_ch.fire !== want.fire || out_ch.running !== want.running ||
            out_ch.fire_duration !== want.fire_duration) begin
          errors++;
          if (errors <= 10)
            $display({"Mismatch on result %0d: expected fire=%0b running=%0b dur=%0d,",
                      " got fire=%0b running=%0b dur=%0d"},
                     results_seen, want.fire, want.running, want.fire_duration,
                     out_ch.fire, out_ch.running, out_ch.fire_duration);
        end
      end
    end
  end

  // Watchdog.
  initial begin
    #2_000_000;
    $display("[triac_phase_angle_trigger_unit] ERROR");
    $finish;
  end

  // Main sequence.
  initial begin
    result_t none;
    none = '0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.mode = MODE_TICK;
    in_ch.line_level = 1'b0;
    in_ch.duration_request = '0;
    errors = 0;
    results_seen = 0;
    fires_seen = 0;
    random_sent = 0;
    holds_asked = 0;
    holds_done = 0;
    settings_used = 1;
    src_idle_pct = 34;
    snk_idle_pct = 68;
    armed = 1'b0;
    ticks_left = 0;
    elapsed_ticks = 0;
    held_ticks = 0;
    window_ticks = MAX_DELAY_RST;
    gap_ticks = REPEAT_GAP_RST;

    // Directed table: reset state, clamp extremes, unused mode, then short windows.
    dir_rows.push_back(checked_row(MODE_TICK, 1'b0, 0, 1'b0, 1'b0, 0));
    dir_rows.push_back(checked_row(MODE_DURATION, 1'b0, 32767, 1'b0, 1'b0, 864));
    dir_rows.push_back(checked_row(MODE_DURATION, 1'b1, -32768, 1'b0, 1'b0, 0));
    dir_rows.push_back(checked_row(MODE_UNUSED, 1'b1, -1, 1'b0, 1'b0, 0));
    dir_rows.push_back(checked_row(MODE_EDGE, 1'b0, 0, 1'b0, 1'b0, 0));
    dir_rows.push_back(checked_row(MODE_EDGE, 1'b1, 0, 1'b0, 1'b0, 0));
    dir_rows.push_back(cfg_row(REG_MAX_DELAY, 6));
    dir_rows.push_back(cfg_row(REG_REPEAT_GAP, 2));
    dir_rows.push_back(checked_row(MODE_DURATION, 1'b0, 4, 1'b0, 1'b0, 4));
    dir_rows.push_back(checked_row(MODE_EDGE, 1'b0, 0, 1'b0, 1'b1, 4));
    repeat (7) dir_rows.push_back(item_row(MODE_TICK, 1'b0, 0));
    // Low edge while running restarts the delay; a high edge stops it.
    dir_rows.push_back(item_row(MODE_EDGE, 1'b0, 0));
    dir_rows.push_back(item_row(MODE_TICK, 1'b1, 0));
    dir_rows.push_back(item_row(MODE_EDGE, 1'b0, 0));
    dir_rows.push_back(item_row(MODE_EDGE, 1'b1, 0));
    // Duration above the window is held at the window and arms the minimum delay.
    dir_rows.push_back(checked_row(MODE_DURATION, 1'b0, 100, 1'b0, 1'b0, 6));
    dir_rows.push_back(item_row(MODE_EDGE, 1'b0, 0));
    dir_rows.push_back(item_row(MODE_TICK, 1'b0, 0));
    // Window lowered below the held duration, and a zero repeat gap.
    dir_rows.push_back(cfg_row(REG_MAX_DELAY, 3));
    dir_rows.push_back(cfg_row(REG_REPEAT_GAP, 0));
    dir_rows.push_back(item_row(MODE_EDGE, 1'b0, 0));
    repeat (4) dir_rows.push_back(item_row(MODE_TICK, 1'b0, 0));

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) begin
        drain();
        cfg_write(dir_rows[i].idx, dir_rows[i].val);
      end else begin
        send_item(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].exp);
      end
    end
    settings_used = settings_used + 2;

    // Random phases, each under its own register setting and idle pattern.
    for (int p = 0; p < NUM_PHASES; p++) begin
      drain();
      if (p < 2) begin
        src_idle_pct = 34;
        snk_idle_pct = 68;
      end else if (p < 4) begin
        src_idle_pct = 68;
        snk_idle_pct = 34;
      end else begin
        src_idle_pct = 0;
        snk_idle_pct = 0;
      end
      cfg_write(REG_MAX_DELAY, FIELD_W'(phase_win[p]));
      cfg_write(REG_REPEAT_GAP, FIELD_W'(phase_gap[p]));
      settings_used++;
      run_phase(p, phase_len[p]);
    end

    drain();
    repeat (10) @(negedge clk);
    if (fire_status_q.size() != 0) errors++;

    $display("Ran %0d directed rows and %0d random transactions under %0d register settings.",
             dir_rows.size(), random_sent, settings_used);
    $display("Checked %0d result transactions, %0d of them fire strobes; %0d failures.",
             results_seen, fires_seen, errors);
    if (errors == 0) begin
      $display("[triac_phase_angle_trigger_unit] OK");
    end else begin
      $display("[triac_phase_angle_trigger_unit] ERROR");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/tpat_pkg.sv
rtl/tpat_if.sv
rtl/tpat_core.sv
rtl/triac_phase_angle_trigger_unit.sv
tb/tb_triac_phase_angle_trigger_unit.sv
